// ===== rtl/core/bss_pkg.sv =====
// Shared types, constants and bit-search functions for the bitmap set
// successor search block. No dependencies.
package bss_pkg;

    localparam int WORD_W     = 64;
    localparam int BIT_W      = 6;
    localparam int LEAF_DEPTH = 64;
    localparam int WADDR_W    = 6;
    localparam int POS_W      = WADDR_W + BIT_W;
    localparam int IN_POS_W   = 13;
    localparam int OP_W       = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST   = 3'd2;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
    localparam logic [OP_W-1:0] OP_PREV   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [IN_POS_W-1:0] position;
    } cmd_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] result_position;
    } rsp_t;

    typedef struct packed {
        logic               we;
        logic [WADDR_W-1:0] waddr;
        logic [WORD_W-1:0]  wdata;
        logic               re;
        logic [WADDR_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEAF,
        ST_DESC,
        ST_RESP
    } state_t;

    function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] x);
        logic [BIT_W-1:0] k;
        k = BIT_W'(WORD_W - 1);
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                k = BIT_W'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [BIT_W-1:0] high_bit(input logic [WORD_W-1:0] x);
        logic [BIT_W-1:0] k;
        k = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (x[i])
            begin
                k = BIT_W'(i);
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/bitmap_set_successor_search.sv =====
// Top level of the bitmap set successor search: leaf RAM, sequencer and the
// response output register. Depends on bss_pkg, bss_leaf_ram, bss_engine.
//
// Keeps a set of positions 0..4095 as 64 leaf words of 64 bits in a synchronous
// RAM with one write port and one read port, with a 64-bit summary register
// marking the nonzero leaf words; the set is empty right out of reset with no
// clearing pass, since a leaf word whose summary bit is clear reads as zero.
// One transaction is in work at a time. Insert, erase, test and a next/prev
// search that hits in the starting leaf word go through ST_LEAF and ST_RESP; a
// search that descends through the summary word to a second leaf word adds
// ST_DESC for that second, dependent leaf RAM read. The response sits in an
// output register, so a new transaction is taken while a response still waits.
module bitmap_set_successor_search (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  bss_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bss_pkg::rsp_t rsp
);
    import bss_pkg::*;

    mem_req_t            mem_req;
    logic [WORD_W-1:0]   mem_rdata;
    logic                res_free;
    logic                res_load;
    rsp_t                res;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    bss_leaf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LEAF_DEPTH)
    ) u_leaf_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    bss_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_free  (res_free),
        .res_load  (res_load),
        .res       (res)
    );

    assign res_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/bss_leaf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bss_leaf_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bss_engine.sv =====
// Operation sequencer: summary word register, leaf read-modify-write and the
// two-level next/prev search. Depends on bss_pkg.
module bss_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  bss_pkg::cmd_t   cmd,
    output bss_pkg::mem_req_t mem_req,
    input  logic [63:0]     mem_rdata,
    input  logic            res_free,
    output logic            res_load,
    output bss_pkg::rsp_t   res
);
    import bss_pkg::*;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                oor_reg, oor_next;
    logic [WORD_W-1:0]   summary_reg, summary_next;
    rsp_t                res_reg, res_next;

    logic [WADDR_W-1:0]  w;
    logic [BIT_W-1:0]    b;
    logic [WORD_W-1:0]   leaf;
    logic [WORD_W-1:0]   bit_mask;
    logic [WORD_W-1:0]   leaf_up, leaf_dn;
    logic [WORD_W-1:0]   sum_up, sum_dn;
    logic [WORD_W-1:0]   new_word;

    assign w        = pos_reg[POS_W-1:BIT_W];
    assign b        = pos_reg[BIT_W-1:0];
    assign leaf     = summary_reg[w] ? mem_rdata : '0;
    assign bit_mask = {{(WORD_W-1){1'b0}}, 1'b1} << b;
    assign leaf_up  = leaf & ({WORD_W{1'b1}} << b);
    assign leaf_dn  = leaf & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - b));
    assign sum_up   = summary_reg & (({WORD_W{1'b1}} << w) << 1);
    assign sum_dn   = summary_reg & ~({WORD_W{1'b1}} << w);
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            summary_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            summary_reg <= summary_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        pos_reg <= pos_next;
        oor_reg <= oor_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        oor_next     = oor_reg;
        summary_next = summary_reg;
        res_next     = res_reg;
        mem_req      = '0;
        res_load     = 1'b0;
        new_word     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next      = cmd.opcode;
                    oor_next     = cmd.position[IN_POS_W-1];
                    pos_next     = cmd.position[IN_POS_W-1] ? {POS_W{1'b1}}
                                                            : cmd.position[POS_W-1:0];
                    mem_req.re    = 1'b1;
                    mem_req.raddr = pos_next[POS_W-1:BIT_W];
                    state_next   = ST_LEAF;
                end
            end

            ST_LEAF:
            begin
                res_next   = '0;
                state_next = ST_RESP;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (!oor_reg)
                        begin
                            new_word        = leaf | bit_mask;
                            mem_req.we      = 1'b1;
                            mem_req.waddr   = w;
                            mem_req.wdata   = new_word;
                            summary_next[w] = 1'b1;
                            res_next.found  = 1'b1;
                        end
                    end
                    OP_ERASE:
                    begin
                        if (!oor_reg)
                        begin
                            new_word        = leaf & ~bit_mask;
                            mem_req.we      = 1'b1;
                            mem_req.waddr   = w;
                            mem_req.wdata   = new_word;
                            summary_next[w] = (new_word != '0);
                            res_next.found  = 1'b1;
                        end
                    end
                    OP_TEST:
                    begin
                        res_next.found = !oor_reg && leaf[b];
                    end
                    OP_NEXT:
                    begin
                        if (oor_reg)
                        begin
                            res_next = '0;
                        end
                        else if (leaf_up != '0)
                        begin
                            res_next.found           = 1'b1;
                            res_next.result_position = {w, low_bit(leaf_up)};
                        end
                        else if (sum_up != '0)
                        begin
                            pos_next      = {low_bit(sum_up), {BIT_W{1'b0}}};
                            mem_req.re    = 1'b1;
                            mem_req.raddr = pos_next[POS_W-1:BIT_W];
                            state_next    = ST_DESC;
                        end
                    end
                    OP_PREV:
                    begin
                        if (leaf_dn != '0)
                        begin
                            res_next.found           = 1'b1;
                            res_next.result_position = {w, high_bit(leaf_dn)};
                        end
                        else if (sum_dn != '0)
                        begin
                            pos_next      = {high_bit(sum_dn), {BIT_W{1'b0}}};
                            mem_req.re    = 1'b1;
                            mem_req.raddr = pos_next[POS_W-1:BIT_W];
                            state_next    = ST_DESC;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end

            ST_DESC:
            begin
                res_next.found = 1'b1;
                if (op_reg == OP_NEXT)
                begin
                    res_next.result_position = {w, low_bit(mem_rdata)};
                end
                else
                begin
                    res_next.result_position = {w, high_bit(mem_rdata)};
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
